### rtl/core/tpms_pkg.sv
package tpms_pkg;

   localparam int MUL_W  = 33;
   localparam int PROD_W = 66;
   localparam int ACC_W  = 82;
   localparam int SIN_W  = 20;
   localparam int ANG_W  = 21;
   localparam int SQ_W   = 47;

   localparam logic [3:0] CSR_COEF_A       = 4'd0;
   localparam logic [3:0] CSR_COEF_B       = 4'd1;
   localparam logic [3:0] CSR_COEF_C       = 4'd2;
   localparam logic [3:0] CSR_COEF_D       = 4'd3;
   localparam logic [3:0] CSR_MODE         = 4'd4;
   localparam logic [3:0] CSR_START_TEMP   = 4'd5;
   localparam logic [3:0] CSR_START_BEFORE = 4'd6;
   localparam logic [3:0] CSR_START_CTRL   = 4'd7;
   localparam logic [3:0] CSR_COUNT        = 4'd8;

   localparam logic [19:0]             TWO_PI_U   = 20'd411775;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q   = 21'sd411775;
   localparam logic signed [ANG_W-1:0] PI_Q       = 21'sd205887;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q  = 21'sd102944;
   localparam logic signed [SIN_W-1:0] CORDIC_GAIN_Q = 20'sd39797;

   // reciprocal of two pi; the quotient estimate is low by at most one
   localparam int          RECIP_SH = 44;
   localparam logic [25:0] RECIP_Q  = 26'((64'd1 << RECIP_SH) / 64'd411775);

   localparam logic signed [ACC_W-1:0] ROUND_Q = 82'sd32768;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_SQR,
      ST_MA,
      ST_MB,
      ST_MBLO,
      ST_MBHI,
      ST_MC,
      ST_WSIN,
      ST_MD,
      ST_FLUSH,
      ST_DONE
   } tpms_state_type;

   typedef enum logic [2:0] {
      SN_IDLE,
      SN_DIV,
      SN_REM,
      SN_FOLD,
      SN_ROT
   } tpms_sine_state_type;

   function automatic logic signed [ANG_W-1:0] atan_q(input logic [3:0] i);
      logic signed [ANG_W-1:0] v;
      unique case (i)
         4'd0:  v = 21'sd51472;
         4'd1:  v = 21'sd30385;
         4'd2:  v = 21'sd16055;
         4'd3:  v = 21'sd8150;
         4'd4:  v = 21'sd4091;
         4'd5:  v = 21'sd2047;
         4'd6:  v = 21'sd1024;
         4'd7:  v = 21'sd512;
         4'd8:  v = 21'sd256;
         4'd9:  v = 21'sd128;
         4'd10: v = 21'sd64;
         4'd11: v = 21'sd32;
         4'd12: v = 21'sd16;
         4'd13: v = 21'sd8;
         4'd14: v = 21'sd4;
         default: v = 21'sd2;
      endcase
      return v;
   endfunction

endpackage

### rtl/core/tpms_sine.sv
module tpms_sine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [31:0]                         angle,
   output logic                                sine_valid,
   output logic signed [tpms_pkg::SIN_W-1:0]   sine
);

   tpms_pkg::tpms_sine_state_type state_ff, state_in;

   logic [4:0]                          cnt_ff, cnt_in;
   logic [31:0]                         dvd_ff, dvd_in;
   logic [13:0]                         quo_ff, quo_in;
   logic [18:0]                         rem_ff, rem_in;
   logic                                neg_ff, neg_in;
   logic signed [tpms_pkg::SIN_W-1:0]   x_ff, x_in;
   logic signed [tpms_pkg::SIN_W-1:0]   y_ff, y_in;
   logic signed [tpms_pkg::ANG_W-1:0]   z_ff, z_in;
   logic                                valid_ff, valid_in;

   logic [57:0]                         mul_q;
   logic [19:0]                         qc;
   logic [19:0]                         diff;
   logic [19:0]                         rem_c;
   logic [19:0]                         r0;
   logic signed [tpms_pkg::ANG_W-1:0]   r1;
   logic signed [tpms_pkg::ANG_W-1:0]   r2;
   logic signed [tpms_pkg::SIN_W-1:0]   x_sh;
   logic signed [tpms_pkg::SIN_W-1:0]   y_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpms_pkg::SN_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      valid_in = valid_ff;

      // quotient estimate by reciprocal product
      mul_q = {26'd0, dvd_ff} * {32'd0, tpms_pkg::RECIP_Q};

      // remainder stays below twice two pi, so 20 bits are exact
      qc   = {6'd0, quo_ff} * tpms_pkg::TWO_PI_U;
      diff = dvd_ff[19:0] - qc;
      if (diff >= tpms_pkg::TWO_PI_U) begin
         rem_c = diff - tpms_pkg::TWO_PI_U;
      end else begin
         rem_c = diff;
      end

      // reduce into [-pi, pi] then fold into [-pi/2, pi/2]
      if (neg_ff && (rem_ff != 19'd0)) begin
         r0 = tpms_pkg::TWO_PI_U - {1'b0, rem_ff};
      end else begin
         r0 = {1'b0, rem_ff};
      end
      r1 = $signed({1'b0, r0});
      if (r1 > tpms_pkg::PI_Q) begin
         r1 = r1 - tpms_pkg::TWO_PI_Q;
      end
      if (r1 > tpms_pkg::HALF_PI_Q) begin
         r2 = tpms_pkg::PI_Q - r1;
      end else if (r1 < -tpms_pkg::HALF_PI_Q) begin
         r2 = -tpms_pkg::PI_Q - r1;
      end else begin
         r2 = r1;
      end

      x_sh = x_ff >>> cnt_ff[3:0];
      y_sh = y_ff >>> cnt_ff[3:0];

      unique case (state_ff)
         tpms_pkg::SN_IDLE: begin
         end
         tpms_pkg::SN_DIV: begin
            quo_in   = mul_q[tpms_pkg::RECIP_SH+13:tpms_pkg::RECIP_SH];
            state_in = tpms_pkg::SN_REM;
         end
         tpms_pkg::SN_REM: begin
            rem_in   = rem_c[18:0];
            state_in = tpms_pkg::SN_FOLD;
         end
         tpms_pkg::SN_FOLD: begin
            z_in     = r2;
            x_in     = tpms_pkg::CORDIC_GAIN_Q;
            y_in     = '0;
            cnt_in   = 5'd0;
            state_in = tpms_pkg::SN_ROT;
         end
         tpms_pkg::SN_ROT: begin
            if (z_ff >= 0) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - tpms_pkg::atan_q(cnt_ff[3:0]);
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + tpms_pkg::atan_q(cnt_ff[3:0]);
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff[3:0] == 4'd15) begin
               state_in = tpms_pkg::SN_IDLE;
               valid_in = 1'b1;
            end
         end
         default: begin
            state_in = tpms_pkg::SN_IDLE;
         end
      endcase

      if (start) begin
         state_in = tpms_pkg::SN_DIV;
         valid_in = 1'b0;
         cnt_in   = 5'd0;
         rem_in   = '0;
         neg_in   = angle[31];
         dvd_in   = angle[31] ? (~angle + 32'd1) : angle;
      end
   end

   assign sine_valid = valid_ff;
   assign sine       = y_ff;

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> state_ff == tpms_pkg::SN_IDLE)
      else $error("sine valid while unit busy");
   a_fold_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpms_pkg::SN_FOLD) |-> ($past(state_ff) == tpms_pkg::SN_REM))
      else $error("fold entered without remainder pass");
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpms_pkg::SN_FOLD) |-> ({1'b0, rem_ff} < tpms_pkg::TWO_PI_U))
      else $error("remainder out of range");

endmodule

### rtl/core/temperature_plant_model_step.sv
// temperature plant model step, signed q16.16
// req channel: one control value per transaction (req_control_input)
// rsp channel: next temperature and a saturation flag per request
// csr port: csr_we with csr_index and csr_wdata writes one register; any
//   write to a register in the map reloads the temperature and control history
// linear mode: states MA, MB, FLUSH and DONE follow acceptance (two products
//   through the shared 33x33 multiplier plus rounding)
// nonlinear mode: the sine unit sets the response time: reciprocal quotient,
//   remainder and fold, then cordic rotation; the square and four products
//   overlap with it on the shared multiplier
// one request is in work at a time; req_stall is high from acceptance until
//   the result is moved into the output register
// a result waiting under rsp_stall does not block the next request; the
//   block only holds its final step until the output register is free
// reset clears the configuration, the history and the control state, no
//   clearing pass
module temperature_plant_model_step (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_control_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_temperature,
   output logic        rsp_saturated,
   input  logic        csr_we,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   tpms_pkg::tpms_state_type state_ff, state_in;

   logic [31:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic        mode_ff;
   logic [31:0] start_temp_ff, start_before_ff, start_ctrl_ff;
   logic [31:0] temp_last_ff, temp_before_ff, ctrl_last_ff;
   logic [31:0] u_ff, u_in;

   logic signed [tpms_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [tpms_pkg::PROD_W-1:0] prod_ff;
   logic                               pend_ff, pend_in;
   logic                               shift_ff, shift_in;
   logic [tpms_pkg::SQ_W-1:0]          sq_ff, sq_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_temperature_ff, rsp_temperature_in;
   logic        rsp_saturated_ff, rsp_saturated_in;

   logic signed [tpms_pkg::MUL_W-1:0]  op_a, op_b;
   logic signed [tpms_pkg::PROD_W-1:0] prod_full;
   logic [31:0]                        abs_y2;
   logic signed [tpms_pkg::MUL_W-1:0]  neg_b;
   logic signed [tpms_pkg::ACC_W-1:0]  addend;
   logic [63:0]                        sq_sum;
   logic                               in_range;
   logic [31:0]                        result;
   logic                               req_take;
   logic                               out_free;
   logic                               finish;
   logic                               sin_start;
   logic                               sin_valid;
   logic signed [tpms_pkg::SIN_W-1:0]  sin_val;

   tpms_sine u_sine (
      .clock      (clock),
      .reset      (reset),
      .start      (sin_start),
      .angle      (ctrl_last_ff),
      .sine_valid (sin_valid),
      .sine       (sin_val)
   );

   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sin_start = req_take && mode_ff;
   assign abs_y2    = temp_before_ff[31] ? (~temp_before_ff + 32'd1) : temp_before_ff;
   assign neg_b     = ~$signed({coef_b_ff[31], coef_b_ff}) + 33'sd1;
   assign prod_full = op_a * op_b;
   assign sq_sum    = prod_ff[63:0] + 64'd32768;
   assign in_range  = (&acc_ff[tpms_pkg::ACC_W-1:47]) || (~|acc_ff[tpms_pkg::ACC_W-1:47]);

   always_comb begin
      if (in_range) begin
         result = acc_ff[47:16];
      end else if (acc_ff[tpms_pkg::ACC_W-1]) begin
         result = 32'h8000_0000;
      end else begin
         result = 32'h7fff_ffff;
      end
      if (shift_ff) begin
         addend = $signed({prod_ff[49:0], 32'd0});
      end else begin
         addend = $signed({{(tpms_pkg::ACC_W - tpms_pkg::PROD_W){prod_ff[65]}}, prod_ff});
      end
   end

   // multiplier operand select
   always_comb begin
      op_a     = '0;
      op_b     = '0;
      pend_in  = 1'b0;
      shift_in = 1'b0;
      unique case (state_ff)
         tpms_pkg::ST_SQ: begin
            op_a = $signed({1'b0, abs_y2});
            op_b = $signed({1'b0, abs_y2});
         end
         tpms_pkg::ST_MA: begin
            op_a    = $signed({coef_a_ff[31], coef_a_ff});
            op_b    = $signed({temp_last_ff[31], temp_last_ff});
            pend_in = 1'b1;
         end
         tpms_pkg::ST_MB: begin
            op_a    = $signed({coef_b_ff[31], coef_b_ff});
            op_b    = $signed({u_ff[31], u_ff});
            pend_in = 1'b1;
         end
         tpms_pkg::ST_MBLO: begin
            op_a    = neg_b;
            op_b    = $signed({1'b0, sq_ff[31:0]});
            pend_in = 1'b1;
         end
         tpms_pkg::ST_MBHI: begin
            op_a     = neg_b;
            op_b     = $signed({18'd0, sq_ff[tpms_pkg::SQ_W-1:32]});
            pend_in  = 1'b1;
            shift_in = 1'b1;
         end
         tpms_pkg::ST_MC: begin
            op_a    = $signed({coef_c_ff[31], coef_c_ff});
            op_b    = $signed({u_ff[31], u_ff});
            pend_in = 1'b1;
         end
         tpms_pkg::ST_MD: begin
            op_a    = $signed({coef_d_ff[31], coef_d_ff});
            op_b    = $signed({{(tpms_pkg::MUL_W - tpms_pkg::SIN_W){sin_val[tpms_pkg::SIN_W-1]}},
                               sin_val});
            pend_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in           = state_ff;
      u_in               = u_ff;
      sq_in              = sq_ff;
      acc_in             = pend_ff ? (acc_ff + addend) : acc_ff;
      finish             = 1'b0;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_temperature_in = rsp_temperature_ff;
      rsp_saturated_in   = rsp_saturated_ff;
      req_stall          = (state_ff != tpms_pkg::ST_IDLE);
      unique case (state_ff)
         tpms_pkg::ST_IDLE: begin
            if (req_valid) begin
               u_in     = req_control_input;
               acc_in   = tpms_pkg::ROUND_Q;
               state_in = mode_ff ? tpms_pkg::ST_SQ : tpms_pkg::ST_MA;
            end
         end
         tpms_pkg::ST_SQ: begin
            state_in = tpms_pkg::ST_SQR;
         end
         tpms_pkg::ST_SQR: begin
            sq_in    = sq_sum[62:16];
            state_in = tpms_pkg::ST_MA;
         end
         tpms_pkg::ST_MA: begin
            state_in = mode_ff ? tpms_pkg::ST_MBLO : tpms_pkg::ST_MB;
         end
         tpms_pkg::ST_MB: begin
            state_in = tpms_pkg::ST_FLUSH;
         end
         tpms_pkg::ST_MBLO: begin
            state_in = tpms_pkg::ST_MBHI;
         end
         tpms_pkg::ST_MBHI: begin
            state_in = tpms_pkg::ST_MC;
         end
         tpms_pkg::ST_MC: begin
            state_in = tpms_pkg::ST_WSIN;
         end
         tpms_pkg::ST_WSIN: begin
            if (sin_valid) begin
               state_in = tpms_pkg::ST_MD;
            end
         end
         tpms_pkg::ST_MD: begin
            state_in = tpms_pkg::ST_FLUSH;
         end
         tpms_pkg::ST_FLUSH: begin
            state_in = tpms_pkg::ST_DONE;
         end
         tpms_pkg::ST_DONE: begin
            if (out_free) begin
               finish             = 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_temperature_in = result;
               rsp_saturated_in   = !in_range;
               state_in           = tpms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tpms_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpms_pkg::ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff           <= shift_in;
      prod_ff            <= prod_full;
      acc_ff             <= acc_in;
      sq_ff              <= sq_in;
      u_ff               <= u_in;
      rsp_temperature_ff <= rsp_temperature_in;
      rsp_saturated_ff   <= rsp_saturated_in;
   end

   // registers and history
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff       <= '0;
         coef_b_ff       <= '0;
         coef_c_ff       <= '0;
         coef_d_ff       <= '0;
         mode_ff         <= 1'b0;
         start_temp_ff   <= '0;
         start_before_ff <= '0;
         start_ctrl_ff   <= '0;
         temp_last_ff    <= '0;
         temp_before_ff  <= '0;
         ctrl_last_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tpms_pkg::CSR_COEF_A:       coef_a_ff       <= csr_wdata;
            tpms_pkg::CSR_COEF_B:       coef_b_ff       <= csr_wdata;
            tpms_pkg::CSR_COEF_C:       coef_c_ff       <= csr_wdata;
            tpms_pkg::CSR_COEF_D:       coef_d_ff       <= csr_wdata;
            tpms_pkg::CSR_MODE:         mode_ff         <= csr_wdata[0];
            tpms_pkg::CSR_START_TEMP:   start_temp_ff   <= csr_wdata;
            tpms_pkg::CSR_START_BEFORE: start_before_ff <= csr_wdata;
            tpms_pkg::CSR_START_CTRL:   start_ctrl_ff   <= csr_wdata;
            default: begin
            end
         endcase
         // reload from the start registers including the value written now
         if (csr_index < tpms_pkg::CSR_COUNT) begin
            temp_last_ff   <= (csr_index == tpms_pkg::CSR_START_TEMP) ?
                              csr_wdata : start_temp_ff;
            temp_before_ff <= (csr_index == tpms_pkg::CSR_START_BEFORE) ?
                              csr_wdata : start_before_ff;
            ctrl_last_ff   <= (csr_index == tpms_pkg::CSR_START_CTRL) ?
                              csr_wdata : start_ctrl_ff;
         end
      end else if (finish) begin
         temp_before_ff <= temp_last_ff;
         temp_last_ff   <= result;
         ctrl_last_ff   <= u_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = rsp_temperature_ff;
   assign rsp_saturated   = rsp_saturated_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == tpms_pkg::ST_DONE))
      else $error("response raised outside final step");
   a_sat_clipped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_saturated_ff) |->
      (rsp_temperature_ff == 32'h7fff_ffff || rsp_temperature_ff == 32'h8000_0000))
      else $error("saturation flag without clipped value");
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpms_pkg::ST_IDLE) |-> !pend_ff)
      else $error("product left unaccumulated");
   a_sine_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpms_pkg::ST_MD) |-> sin_valid)
      else $error("sine product without sine result");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_temperature_ff))
      else $error("waiting response overwritten");

endmodule
